>>> hw/rtl/pfmbs_pkg.sv
package pfmbs_pkg;

    localparam int WORDS_IN = 6;

    localparam logic [31:0] EMPTY_ONES    = 32'hffff_ffff;
    localparam logic [31:0] MEM_BASE_MASK = 32'hffff_fff0;

    localparam logic [1:0] TYPE_MEM32 = 2'd0;
    localparam logic [1:0] TYPE_MEM64 = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_MEM32 = 2'd1;
    localparam logic [1:0] KIND_MEM64 = 2'd2;

    typedef logic [WORDS_IN-1:0][31:0] t_words;

    typedef struct packed {
        logic [31:0] bar_word0;
        logic [31:0] bar_word1;
        logic [31:0] bar_word2;
        logic [31:0] bar_word3;
        logic [31:0] bar_word4;
        logic [31:0] bar_word5;
    } t_bar_in;

    typedef struct packed {
        logic        found;
        logic [2:0]  bar_slot;
        logic [1:0]  bar_kind;
        logic [63:0] base_address;
        logic        prefetchable;
    } t_bar_out;

    // scan state handed from cell to cell
    typedef struct packed {
        logic     valid;
        logic     skip;
        t_bar_out res;
    } t_scan;

endpackage

>>> hw/rtl/pfmbs_cell.sv
module pfmbs_cell
    import pfmbs_pkg::*;
#(
    parameter int SLOT   = 0,
    parameter bit HAS_HI = 1'b1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_scan  i_scan,
    input  t_words i_words,
    output t_scan  o_scan,
    output t_words o_words
);

    localparam int HI_IDX = (SLOT + 1 < WORDS_IN) ? SLOT + 1 : SLOT;

    t_scan       r_scan;
    t_scan       n_scan;
    t_words      r_words;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        empty;
    logic        is_mem32;
    logic        is_mem64;
    logic [63:0] base;
    logic        active;
    logic        pick;

    always_comb begin
        lo       = i_words[SLOT];
        hi       = HAS_HI ? i_words[HI_IDX] : 32'd0;
        empty    = (lo == 32'd0) || (lo == EMPTY_ONES) || lo[0];
        is_mem32 = !empty && (lo[2:1] == TYPE_MEM32);
        is_mem64 = !empty && (lo[2:1] == TYPE_MEM64);
        base     = is_mem64 ? {hi, lo & MEM_BASE_MASK} : {32'd0, lo & MEM_BASE_MASK};
        active   = i_scan.valid && !i_scan.res.found && !i_scan.skip;
        pick     = active && (is_mem32 || is_mem64) && (base != 64'd0);

        n_scan       = i_scan;
        // a zero-base 64-bit BAR consumes its partner slot
        n_scan.skip  = active && is_mem64 && (base == 64'd0) && HAS_HI;
        if (pick) begin
            n_scan.res.found        = 1'b1;
            n_scan.res.bar_slot     = 3'(SLOT);
            n_scan.res.bar_kind     = is_mem64 ? KIND_MEM64 : KIND_MEM32;
            n_scan.res.base_address = base;
            n_scan.res.prefetchable = lo[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan.valid <= n_scan.valid;
        end
        r_scan.skip <= n_scan.skip;
        r_scan.res  <= n_scan.res;
        r_words     <= i_words;
    end

    assign o_scan  = r_scan;
    assign o_words = r_words;

endmodule

>>> hw/rtl/pci_first_mmio_bar_select_core.sv
// channel  | ports                       | beat taken when
// ---------+-----------------------------+-------------------
// header   | start, busy, i_bar          | start && !busy
// result   | o_done, o_result            | o_done (one cycle)
//
// One header per cycle; each result is registered once in every slot cell of
// the scan chain on its way to the output.
// busy stays low: every cell registers its beat each cycle.
// Synchronous active-low reset clears the valid bits of the chain only.
// The receiver cannot stall; results are shown for exactly one cycle.
module pci_first_mmio_bar_select_core
    import pfmbs_pkg::*;
#(
    parameter int BAR_SLOTS = 6
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_bar_in  i_bar,
    output logic     busy,
    output logic     o_done,
    output t_bar_out o_result
);

    localparam int NSLOT = (BAR_SLOTS < 1) ? 1 : (BAR_SLOTS > WORDS_IN) ? WORDS_IN : BAR_SLOTS;

    t_scan  scan  [NSLOT+1];
    t_words words [NSLOT+1];

    assign busy = 1'b0;

    assign scan[0]  = '{valid: start && !busy, skip: 1'b0, res: '0};
    assign words[0] = {i_bar.bar_word5, i_bar.bar_word4, i_bar.bar_word3,
                       i_bar.bar_word2, i_bar.bar_word1, i_bar.bar_word0};

    for (genvar g = 0; g < NSLOT; g++) begin : g_cell
        pfmbs_cell #(
            .SLOT   (g),
            .HAS_HI (g + 1 < NSLOT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_scan  (scan[g]),
            .i_words (words[g]),
            .o_scan  (scan[g+1]),
            .o_words (words[g+1])
        );
    end

    assign o_done   = scan[NSLOT].valid;
    assign o_result = scan[NSLOT].res;

endmodule

>>> hw/rtl/pfmbs_checker.sv
module pfmbs_checker
    import pfmbs_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input t_bar_in  i_bar,
    input logic     busy,
    input logic     o_done,
    input t_bar_out o_result
);

    // no match: every field is zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.found |-> o_result.bar_slot == 3'd0
            && o_result.bar_kind == KIND_NONE && o_result.base_address == 64'd0
            && !o_result.prefetchable)
        else $error("empty result carries nonzero fields");

    a_found_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.found |-> (o_result.bar_kind == KIND_MEM32
            || o_result.bar_kind == KIND_MEM64) && o_result.base_address != 64'd0
            && o_result.base_address[3:0] == 4'd0 && o_result.bar_slot < 3'd6)
        else $error("found result malformed");

    a_mem32_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.found && o_result.bar_kind == KIND_MEM32
            |-> o_result.base_address[63:32] == 32'd0)
        else $error("32-bit BAR with upper base bits");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !busy)
        else $error("busy raised");

endmodule

bind pci_first_mmio_bar_select_core pfmbs_checker u_pfmbs_checker (.*);

>>> bench/bar_select_checker.sv
`timescale 1ns / 1ps

module bar_select_checker
    import pfmbs_pkg::*;
#(
    parameter int BAR_SLOTS = 6
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_bar_in  i_bar,
    input  logic     i_done,
    input  t_bar_out i_result,
    output int       o_fail_count,
    output int       o_outstanding,
    output int       o_headers,
    output int       o_hits32,
    output int       o_hits64
);

    t_bar_out picks_due[$];
    t_bar_out want;
    int       fails   = 0;
    int       pending = 0;
    int       headers = 0;
    int       hits32  = 0;
    int       hits64  = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = pending;
    assign o_headers     = headers;
    assign o_hits32      = hits32;
    assign o_hits64      = hits64;

    // Scan slots in order; first memory BAR with a nonzero base wins.
    function automatic t_bar_out pick_mmio_bar(input t_bar_in hdr);
        logic [31:0] w [WORDS_IN];
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] base;
        logic [1:0]  mtype;
        int          slot;
        int          n;
        t_bar_out    pick;
        w[0] = hdr.bar_word0;
        w[1] = hdr.bar_word1;
        w[2] = hdr.bar_word2;
        w[3] = hdr.bar_word3;
        w[4] = hdr.bar_word4;
        w[5] = hdr.bar_word5;
        n = BAR_SLOTS;
        if (n < 1) n = 1;
        if (n > WORDS_IN) n = WORDS_IN;
        pick = '0;
        slot = 0;
        while (slot < n) begin
            lo = w[slot];
            hi = (slot + 1 < n) ? w[slot + 1] : 32'd0;
            // empty slot or I/O BAR
            if (lo == 32'd0 || lo == EMPTY_ONES || lo[0]) begin
                slot++;
                continue;
            end
            mtype = lo[2:1];
            if (mtype == TYPE_MEM32) begin
                base = {32'd0, lo & MEM_BASE_MASK};
            end else if (mtype == TYPE_MEM64) begin
                base = {hi, lo & MEM_BASE_MASK};
            end else begin
                slot++;
                continue;
            end
            if (base != 64'd0) begin
                pick.found        = 1'b1;
                pick.bar_slot     = slot[2:0];
                pick.bar_kind     = (mtype == TYPE_MEM64) ? KIND_MEM64 : KIND_MEM32;
                pick.base_address = base;
                pick.prefetchable = lo[3];
                return pick;
            end
            // an unused 64-bit BAR also consumes its upper-half slot
            slot += (mtype == TYPE_MEM64 && slot + 1 < n) ? 2 : 1;
        end
        return pick;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fails++;
        end
    endtask

    // results leave before new headers enter: the result path must be registered
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_done) begin
                if (picks_due.size() == 0) begin
                    $error("result beat with no header outstanding (base 0x%0h)",
                           i_result.base_address);
                    fails++;
                end else begin
                    want = picks_due.pop_front();
                    check_field("found", 64'(want.found), 64'(i_result.found));
                    check_field("bar_slot", 64'(want.bar_slot),
                                64'(i_result.bar_slot));
                    check_field("bar_kind", 64'(want.bar_kind),
                                64'(i_result.bar_kind));
                    check_field("base_address", want.base_address,
                                i_result.base_address);
                    check_field("prefetchable", 64'(want.prefetchable),
                                64'(i_result.prefetchable));
                    if (want.bar_kind == KIND_MEM32) hits32++;
                    if (want.bar_kind == KIND_MEM64) hits64++;
                end
            end
            if (i_start && !i_busy) begin
                picks_due.push_back(pick_mmio_bar(i_bar));
                headers++;
            end
            pending = picks_due.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pfmbs_pkg::*;

    localparam int BAR_SLOTS     = 6;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CYCLE_LIMIT   = 200000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_bar_in  i_bar   = '0;
    logic     busy;
    logic     o_done;
    t_bar_out o_result;

    int fail_count;
    int outstanding;
    int headers;
    int hits32;
    int hits64;
    int cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    pci_first_mmio_bar_select_core #(
        .BAR_SLOTS(BAR_SLOTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_bar   (i_bar),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    bar_select_checker #(
        .BAR_SLOTS(BAR_SLOTS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_bar        (i_bar),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .o_headers    (headers),
        .o_hits32     (hits32),
        .o_hits64     (hits64)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic push_header(input t_bar_in hdr, input bit allow_gap);
        while (allow_gap && $urandom_range(99) < 14) begin
            start <= 1'b0;
            i_bar <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_bar <= hdr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly well-formed headers: empties, I/O, 32/64-bit memory BARs,
    // reserved types, zero bases, and some raw noise words.
    function automatic t_bar_in make_header();
        logic [31:0] w [WORDS_IN];
        logic [31:0] r;
        logic [27:0] hi_bits;
        int          slot;
        int          pct;
        slot = 0;
        while (slot < WORDS_IN) begin
            pct     = $urandom_range(99);
            r       = $urandom;
            hi_bits = ($urandom_range(4) == 0) ? 28'd0 : r[31:4];
            if (pct < 12) begin
                w[slot] = 32'd0;
            end else if (pct < 18) begin
                w[slot] = EMPTY_ONES;
            end else if (pct < 30) begin
                w[slot] = r | 32'd1;
            end else if (pct < 50) begin
                w[slot] = {hi_bits, r[3], TYPE_MEM32, 1'b0};
            end else if (pct < 72) begin
                w[slot] = {hi_bits, r[3], TYPE_MEM64, 1'b0};
                if (slot + 1 < WORDS_IN) begin
                    slot++;
                    w[slot] = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
                end
            end else if (pct < 80) begin
                w[slot] = {hi_bits, r[3], r[2], 1'b1, 1'b0};
            end else begin
                w[slot] = r;
            end
            slot++;
        end
        return {w[0], w[1], w[2], w[3], w[4], w[5]};
    endfunction

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed headers
        push_header('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        push_header('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b1);
        push_header('{32'h1, 32'hffff_fffd, 32'h1, 32'hffff_fffd,
                      32'h1, 32'hffff_fffd}, 1'b1);
        push_header('{32'hffff_fff8, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        push_header('{32'h0000_0010, 32'hffff_fff0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        // 64-bit with zero low half, upper half alone makes the base
        push_header('{32'h0000_000c, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        push_header('{32'hffff_fffc, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        // zero-base 64-bit skips its partner, then a 32-bit BAR
        push_header('{32'h4, 32'h0, 32'h1000_0000, 32'h0, 32'h0, 32'h0}, 1'b1);
        // 64-bit in last slot: upper half is zero
        push_header('{32'h0, 32'h1, 32'hffff_ffff, 32'h0, 32'h1, 32'h8000_0004}, 1'b1);
        push_header('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_000c}, 1'b1);
        // zero-base 32-bit is passed over
        push_header('{32'h8, 32'h2000_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        // reserved memory types are ignored
        push_header('{32'h1000_0002, 32'h1000_0006, 32'hffff_fffe,
                      32'h3000_0000, 32'h0, 32'h0}, 1'b1);
        push_header('{32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h4000_0008}, 1'b1);
        push_header('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0004, 32'h0000_0001}, 1'b1);
        // partner word that would decode as memory is only an upper half
        push_header('{32'h4, 32'h5000_0000, 32'h6000_0000, 32'h0, 32'h0, 32'h0}, 1'b1);
        push_header('{32'haaaa_aaaa, 32'h5555_5550, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        push_header('{32'h5555_5554, 32'haaaa_aaaa, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        push_header('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_fff8}, 1'b1);

        // random headers, back to back in the middle stretch
        for (int k = 0; k < RANDOM_ITEMS; k++)
            push_header(make_header(), !(k >= 150 && k < 300));
        start <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (BAR_SLOTS + 8) @(posedge i_clk);

        $display("Covered %0d headers: %0d picked a 32-bit BAR, %0d a 64-bit BAR,",
                 headers, hits32, hits64);
        $display("%0d found no memory BAR.", headers - hits32 - hits64);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pfmbs_pkg.sv
hw/rtl/pfmbs_cell.sv
hw/rtl/pci_first_mmio_bar_select_core.sv
hw/rtl/pfmbs_checker.sv
bench/bar_select_checker.sv
bench/tb.sv
